### rtl/core/tlu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlu_pkg;

    // Default geometry
    localparam int LATTICE_SITES_DEF = 128;
    localparam int COUNT_WIDTH_DEF   = 32;

    // Fixed field widths
    localparam int SITE_W      = 8;
    localparam int UNIFORM_W   = 16;
    localparam int PROB_W      = 17;
    localparam int INTERVAL_W  = 16;
    localparam int STEP_W      = 32;
    localparam int DENSITY_W   = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Read-out mux: sites per first-level group
    localparam int READ_GROUP = 16;

    // Register values after reset
    localparam logic [PROB_W-1:0]     ENTRY_PROB_RST      = 17'd19661;
    localparam logic [PROB_W-1:0]     EXIT_PROB_RST       = 17'd58982;
    localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = 16'd100;
    localparam logic [STEP_W-1:0]     WARMUP_STEPS_RST    = 32'd100000;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_STEP  = 2'd1,
        REQ_READ  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_ENTRY = 2'd1,
        ACT_EXIT  = 2'd2,
        ACT_HOP   = 2'd3
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENTRY_PROB      = 8'd0,
        CFG_EXIT_PROB       = 8'd1,
        CFG_SAMPLE_INTERVAL = 8'd2,
        CFG_WARMUP_STEPS    = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [SITE_W-1:0]    site;
        logic                 occupancy;
        logic [UNIFORM_W-1:0] uniform;
    } tlu_in_t;

    typedef struct packed {
        logic [1:0]           action;
        logic                 sampled;
        logic                 occupied;
        logic [DENSITY_W-1:0] density_count;
    } tlu_out_t;

    // Broadcast to every cell, already qualified by the input handshake
    typedef struct packed {
        logic wr_en;
        logic wr_occ;
        logic step;
        logic sample;
    } tlu_cell_ctl_t;

endpackage

`default_nettype wire

### rtl/core/tlu_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One lattice site: occupancy bit plus saturating density counter.
module tlu_cell
    import tlu_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tlu_cell_ctl_t          ctl,
    input  wire logic                   sel_self,   // item names this site
    input  wire logic                   sel_left,   // item names left neighbor
    input  wire logic                   left_full,  // left neighbor can hand a particle
    input  wire logic                   right_free, // right neighbor can take a particle
    output logic                        occ,
    output logic [COUNT_WIDTH-1:0]      count,
    output logic                        move_out
);

    logic                   occ_reg;
    logic                   occ_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   move_in;

    always_comb
    begin
        move_out = ctl.step & sel_self & occ_reg & right_free;
        move_in  = ctl.step & sel_left & left_full & ~occ_reg;

        occ_next = occ_reg;
        if (ctl.wr_en & sel_self)
        begin
            occ_next = ctl.wr_occ;
        end
        else if (move_out)
        begin
            occ_next = 1'b0;
        end
        else if (move_in)
        begin
            occ_next = 1'b1;
        end

        // sample sees the lattice after this step's move
        count_next = count_reg;
        if (ctl.sample & occ_next & (count_reg != '1))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            occ_reg   <= occ_next;
            count_reg <= count_next;
        end
    end

    assign occ   = occ_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

### rtl/core/tlu_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial restoring remainder: dividend % divisor, one dividend bit per cycle.
module tlu_mod_unit
    import tlu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [STEP_W-1:0]     dividend,
    input  wire logic [INTERVAL_W-1:0] divisor,
    output logic                       busy,
    output logic                       fin,
    output logic [INTERVAL_W-1:0]      rem
);

    localparam int IDX_W = $clog2(STEP_W);

    logic                  busy_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [INTERVAL_W-1:0] rem_reg;
    logic [INTERVAL_W-1:0] rem_next;
    logic [INTERVAL_W:0]   shifted;

    always_comb
    begin
        shifted = {rem_reg, dividend[idx_reg]};
        if (shifted >= {1'b0, divisor})
        begin
            rem_next = INTERVAL_W'(shifted - {1'b0, divisor});
        end
        else
        begin
            rem_next = shifted[INTERVAL_W-1:0];
        end
        fin = busy_reg & (idx_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '1;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_reg - 1'b1;
            if (fin)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_next;

endmodule

`default_nettype wire

### rtl/core/tasep_lattice_update.sv
// A result word is registered in stage 1 and then in the stage 2 output register, which drives out_word.
// Throughput: one word per cycle while in_stall is low; every site is a cell that updates in the accept cycle.
// A write to sample_interval holds in_stall high and cfg_ready low while the serial
// remainder unit realigns the sampling phase to the step count.
// Reset (rst_n, async, active low): lattice empty, counters and step count zero,
// registers at 19661 / 58982 / 100 / 100000, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module tasep_lattice_update
    import tlu_pkg::*;
#(
    parameter int LATTICE_SITES = LATTICE_SITES_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire tlu_in_t                in_word,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output tlu_out_t                    out_word,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Site compare width: wide enough for the entry code LATTICE_SITES
    localparam int SW     = ($clog2(LATTICE_SITES + 1) > SITE_W) ?
                            $clog2(LATTICE_SITES + 1) : SITE_W;
    // Read-out mux geometry: groups of READ_GROUP sites, padded to a power of two
    localparam int NGRP   = (LATTICE_SITES + READ_GROUP - 1) / READ_GROUP;
    localparam int GW     = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int NGRP_P = 1 << GW;
    localparam int LW     = $clog2(READ_GROUP);
    localparam int AW     = GW + LW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PROB_W-1:0]     entry_prob_reg;
    logic [PROB_W-1:0]     exit_prob_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [STEP_W-1:0]     warmup_reg;
    logic                  cfg_wr;
    logic                  mod_start;
    logic                  mod_busy;
    logic                  mod_fin;
    logic [INTERVAL_W-1:0] mod_rem;

    assign cfg_ready = ~mod_busy;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign mod_start = cfg_wr & (cfg_index == CFG_SAMPLE_INTERVAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_prob_reg <= ENTRY_PROB_RST;
            exit_prob_reg  <= EXIT_PROB_RST;
            interval_reg   <= SAMPLE_INTERVAL_RST;
            warmup_reg     <= WARMUP_STEPS_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_ENTRY_PROB:      entry_prob_reg <= cfg_data[PROB_W-1:0];
                CFG_EXIT_PROB:       exit_prob_reg  <= cfg_data[PROB_W-1:0];
                CFG_SAMPLE_INTERVAL: interval_reg   <= cfg_data[INTERVAL_W-1:0];
                CFG_WARMUP_STEPS:    warmup_reg     <= cfg_data[STEP_W-1:0];
                default:             ; // unmapped index: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic                     in_acc;
    logic                     s1_valid_reg;
    logic                     s1_move;
    logic [SW-1:0]            site_ext;
    logic                     step_acc;
    logic                     entry_sel;
    logic                     entry_pass;
    logic                     exit_pass;
    logic                     rd_ok;
    logic [AW-1:0]            rd_idx;
    logic [LATTICE_SITES-1:0] sel;
    logic [LATTICE_SITES-1:0] occ;
    logic [LATTICE_SITES-1:0] move_out;
    logic [COUNT_WIDTH-1:0]   cnt [LATTICE_SITES];
    tlu_cell_ctl_t            ctl;

    // a new word enters when the remainder unit is idle and stage 1 is empty or draining this cycle
    assign in_stall = mod_busy | (s1_valid_reg & ~s1_move);
    assign in_acc   = in_valid & ~in_stall;

    assign site_ext   = SW'(in_word.site);
    assign step_acc   = in_acc & (in_word.req_type == REQ_STEP);
    assign entry_sel  = (site_ext == SW'(LATTICE_SITES));
    assign entry_pass = ({1'b0, in_word.uniform} < entry_prob_reg);
    assign exit_pass  = ({1'b0, in_word.uniform} < exit_prob_reg);
    assign rd_ok      = (in_word.req_type == REQ_READ) && (site_ext < SW'(LATTICE_SITES));
    assign rd_idx     = AW'(in_word.site);

    // ------------------------------------------------------------------
    // Step counter and sampling phase (phase = step_count % interval)
    // ------------------------------------------------------------------
    logic [STEP_W-1:0]     step_count_reg;
    logic [STEP_W-1:0]     step_count_next;
    logic [INTERVAL_W-1:0] phase_reg;
    logic [INTERVAL_W-1:0] phase_next;
    logic [INTERVAL_W-1:0] phase_step;
    logic [INTERVAL_W:0]   phase_inc;
    logic [STEP_W-1:0]     step_inc;
    logic                  sample_hit;

    always_comb
    begin
        step_inc  = step_count_reg + 1'b1;
        phase_inc = {1'b0, phase_reg} + 1'b1;
        // wrap of the step count restarts the phase at zero
        if ((step_inc == '0) || (phase_inc == {1'b0, interval_reg}))
        begin
            phase_step = '0;
        end
        else
        begin
            phase_step = phase_inc[INTERVAL_W-1:0];
        end
        sample_hit = step_acc && (interval_reg != '0) && (phase_step == '0) &&
                     (step_inc > warmup_reg);

        step_count_next = step_count_reg;
        phase_next      = phase_reg;
        if (mod_fin)
        begin
            phase_next = mod_rem;
        end
        else if (step_acc)
        begin
            step_count_next = step_inc;
            phase_next      = phase_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= '0;
            phase_reg      <= '0;
        end
        else
        begin
            step_count_reg <= step_count_next;
            phase_reg      <= phase_next;
        end
    end

    tlu_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (step_count_reg),
        .divisor  (interval_reg),
        .busy     (mod_busy),
        .fin      (mod_fin),
        .rem      (mod_rem)
    );

    // ------------------------------------------------------------------
    // Row of cells. Left of site 0 is the entry reservoir, right of the
    // last site is the exit reservoir.
    // ------------------------------------------------------------------
    always_comb
    begin
        ctl.wr_en  = in_acc & (in_word.req_type == REQ_WRITE);
        ctl.wr_occ = in_word.occupancy;
        ctl.step   = step_acc;
        ctl.sample = sample_hit;
    end

    for (genvar i = 0; i < LATTICE_SITES; i++)
    begin : g_cell
        logic sel_left;
        logic left_full;
        logic right_free;

        assign sel[i] = (site_ext == SW'(i));

        if (i == 0)
        begin : g_first
            assign sel_left  = entry_sel;
            assign left_full = entry_pass;
        end
        else
        begin : g_inner_l
            assign sel_left  = sel[i-1];
            assign left_full = occ[i-1];
        end

        if (i == LATTICE_SITES - 1)
        begin : g_last
            assign right_free = exit_pass;
        end
        else
        begin : g_inner_r
            assign right_free = ~occ[i+1];
        end

        tlu_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .sel_self   (sel[i]),
            .sel_left   (sel_left),
            .left_full  (left_full),
            .right_free (right_free),
            .occ        (occ[i]),
            .count      (cnt[i]),
            .move_out   (move_out[i])
        );
    end

    // ------------------------------------------------------------------
    // Stage 1: step outcome, first level of the read-out mux
    // ------------------------------------------------------------------
    logic                   pad_occ [NGRP_P][READ_GROUP];
    logic [COUNT_WIDTH-1:0] pad_cnt [NGRP_P][READ_GROUP];
    logic                   grp_occ_next [NGRP_P];
    logic [COUNT_WIDTH-1:0] grp_cnt_next [NGRP_P];
    logic                   grp_occ_reg  [NGRP_P];
    logic [COUNT_WIDTH-1:0] grp_cnt_reg  [NGRP_P];
    action_t                action_next;
    action_t                s1_action_reg;
    logic                   s1_sampled_reg;
    logic                   s1_rd_ok_reg;
    logic [GW-1:0]          s1_grp_reg;

    for (genvar p = 0; p < NGRP_P * READ_GROUP; p++)
    begin : g_pad
        if (p < LATTICE_SITES)
        begin : g_site
            assign pad_occ[p / READ_GROUP][p % READ_GROUP] = occ[p];
            assign pad_cnt[p / READ_GROUP][p % READ_GROUP] = cnt[p];
        end
        else
        begin : g_none
            assign pad_occ[p / READ_GROUP][p % READ_GROUP] = 1'b0;
            assign pad_cnt[p / READ_GROUP][p % READ_GROUP] = '0;
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGRP_P; g++)
        begin
            grp_occ_next[g] = pad_occ[g][rd_idx[LW-1:0]];
            grp_cnt_next[g] = pad_cnt[g][rd_idx[LW-1:0]];
        end

        // at most one cell moves, so the move kind follows from which one
        action_next = ACT_NONE;
        if (step_acc)
        begin
            if (entry_sel && entry_pass && !occ[0])
            begin
                action_next = ACT_ENTRY;
            end
            else if (move_out[LATTICE_SITES-1])
            begin
                action_next = ACT_EXIT;
            end
            else if (|move_out[LATTICE_SITES-2:0])
            begin
                action_next = ACT_HOP;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_action_reg  <= action_next;
            s1_sampled_reg <= sample_hit;
            s1_rd_ok_reg   <= rd_ok;
            s1_grp_reg     <= rd_idx[AW-1:LW];
            for (int g = 0; g < NGRP_P; g++)
            begin
                grp_occ_reg[g] <= grp_occ_next[g];
                grp_cnt_reg[g] <= grp_cnt_next[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: output register
    // ------------------------------------------------------------------
    logic     out_valid_reg;
    tlu_out_t out_word_reg;
    tlu_out_t out_word_next;

    assign s1_move = s1_valid_reg & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        out_word_next.action        = s1_action_reg;
        out_word_next.sampled       = s1_sampled_reg;
        out_word_next.occupied      = s1_rd_ok_reg & grp_occ_reg[s1_grp_reg];
        out_word_next.density_count = s1_rd_ok_reg ?
                                      DENSITY_W'(grp_cnt_reg[s1_grp_reg]) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc | (s1_valid_reg & ~s1_move);
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (~out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        mod_busy |-> in_stall)
        else $error("input accepted while phase realign runs");

    a_single_move: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(move_out))
        else $error("more than one cell moved in a step");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!mod_busy && interval_reg != '0) |-> (phase_reg < interval_reg))
        else $error("sampling phase out of range");

    a_step_word_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_word.sampled || out_word.action != ACT_NONE)) |->
        (!out_word.occupied && out_word.density_count == '0))
        else $error("step result carries read data");

    a_sample_after_warmup: assert property (@(posedge clk) disable iff (!rst_n)
        sample_hit |=> (step_count_reg > warmup_reg))
        else $error("sample taken before warm-up ended");

endmodule

`default_nettype wire

### tb/tasep_lattice_update_test.sv
`timescale 1ns / 1ps

module tasep_lattice_update_test;
    import tlu_pkg::*;

    localparam int SITES       = LATTICE_SITES_DEF;
    localparam int COUNT_W     = COUNT_WIDTH_DEF;
    // Slowest legal run is ~1500 words plus receiver and config stalls;
    // this limit is far above it.
    localparam int CYCLE_LIMIT = 400000;

    // req_type value with no meaning; the block must answer with an all-zero word
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Receiver stall patterns
    localparam int STALL_OFF    = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_BURSTS = 2;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    tlu_in_t    in_word = '0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    tlu_out_t   out_word;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    tasep_lattice_update #(
        .LATTICE_SITES (SITES),
        .COUNT_WIDTH   (COUNT_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: lattice, density counters, step counter, registers
    // ------------------------------------------------------------------
    bit                  lattice_occ [SITES];
    bit [DENSITY_W-1:0]  density [SITES];
    bit [STEP_W-1:0]     step_total;
    bit [PROB_W-1:0]     entry_q     = ENTRY_PROB_RST;
    bit [PROB_W-1:0]     exit_q      = EXIT_PROB_RST;
    bit [INTERVAL_W-1:0] interval_q  = SAMPLE_INTERVAL_RST;
    bit [STEP_W-1:0]     warmup_q    = WARMUP_STEPS_RST;

    tlu_out_t pending_results[$];   // expected result words, oldest first

    int error_count;
    int words_sent;
    int results_checked;
    int samples_taken;
    int settings_used;
    int move_tally [4];
    int burst_left;
    int cycle_count;

    // Next state of the lattice for one accepted word, and the result word it yields
    function automatic tlu_out_t tasep_next(input tlu_in_t w);
        tlu_out_t    r;
        int unsigned s;
        r = '0;
        s = 32'(w.site);
        case (w.req_type)
            REQ_WRITE:
            begin
                if (s < SITES)
                    lattice_occ[s] = w.occupancy;
            end
            REQ_STEP:
            begin
                if (s == SITES)
                begin
                    // left boundary: inject into an empty first site
                    if (!lattice_occ[0] && {1'b0, w.uniform} < entry_q)
                    begin
                        lattice_occ[0] = 1'b1;
                        r.action = ACT_ENTRY;
                    end
                end
                else if (s == SITES - 1)
                begin
                    // right boundary: particle leaves
                    if (lattice_occ[SITES-1] && {1'b0, w.uniform} < exit_q)
                    begin
                        lattice_occ[SITES-1] = 1'b0;
                        r.action = ACT_EXIT;
                    end
                end
                else if (s < SITES - 1)
                begin
                    if (lattice_occ[s] && !lattice_occ[s+1])
                    begin
                        lattice_occ[s]   = 1'b0;
                        lattice_occ[s+1] = 1'b1;
                        r.action = ACT_HOP;
                    end
                end
                // sites past the entry selector: no move, but the step counts
                step_total = step_total + 1;
                if (step_total > warmup_q && interval_q != 0 &&
                    step_total % interval_q == 0)
                begin
                    for (int i = 0; i < SITES; i++)
                        if (lattice_occ[i] && density[i] != '1)
                            density[i] = density[i] + 1;
                    r.sampled = 1'b1;
                    samples_taken++;
                end
                move_tally[r.action]++;
            end
            REQ_READ:
            begin
                if (s < SITES)
                begin
                    r.occupied      = lattice_occ[s];
                    r.density_count = density[s];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic tlu_in_t mk(input logic [1:0] rq, input int unsigned st,
                                   input bit oc, input int unsigned un);
        tlu_in_t w;
        w.req_type  = rq;
        w.site      = st[SITE_W-1:0];
        w.occupancy = oc;
        w.uniform   = un[UNIFORM_W-1:0];
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one word per call, bursts of random length, random gaps
    // ------------------------------------------------------------------
    task automatic send_word(input tlu_in_t w);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(tasep_next(w));
        words_sent++;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
        else
            burst_left--;
    endtask

    task automatic end_burst();
        in_valid  <= 1'b0;
        burst_left = 0;
    endtask

    // Idle means every expected result is back; every word yields one result
    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high so back-to-back writes need no second assignment
    task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ENTRY_PROB:      entry_q    = val[PROB_W-1:0];
            CFG_EXIT_PROB:       exit_q     = val[PROB_W-1:0];
            CFG_SAMPLE_INTERVAL: interval_q = val[INTERVAL_W-1:0];
            CFG_WARMUP_STEPS:    warmup_q   = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input bit [PROB_W-1:0] e, input bit [PROB_W-1:0] x,
                              input bit [INTERVAL_W-1:0] iv, input bit [STEP_W-1:0] wu,
                              input bit poke_unused);
        wait_idle();
        cfg_put(CFG_ENTRY_PROB, 32'(e));
        cfg_put(CFG_EXIT_PROB, 32'(x));
        cfg_put(CFG_SAMPLE_INTERVAL, 32'(iv));
        cfg_put(CFG_WARMUP_STEPS, wu);
        // index past the register list must leave everything alone
        if (poke_unused)
            cfg_put(CFG_INDEX_W'($urandom_range(int'(CFG_WARMUP_STEPS) + 1, 255)),
                    $urandom);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly steps near the boundaries and in the bulk, some writes and reads,
    // a little noise: invalid sites and the unused request code
    function automatic tlu_in_t random_word();
        tlu_in_t         w;
        int              roll;
        int              pick;
        bit [PROB_W-1:0] p;
        w = mk(REQ_STEP, 0, 1'($urandom), $urandom);
        roll = $urandom_range(0, 99);
        if (roll < 10)
            w = mk(REQ_WRITE, $urandom_range(0, SITES - 1), 1'($urandom), $urandom);
        else if (roll < 18)
            w = mk(REQ_READ, $urandom_range(0, SITES - 1), 1'($urandom), $urandom);
        else if (roll == 18)
            w = mk(REQ_READ, $urandom_range(SITES, 255), 1'($urandom), $urandom);
        else if (roll == 19)
            w = mk(REQ_UNUSED, $urandom, 1'($urandom), $urandom);
        else if (roll == 20)
            w = mk(REQ_WRITE, $urandom_range(SITES, 255), 1'($urandom), $urandom);
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                w.site = SITE_W'(SITES);
            else if (pick < 24)
                w.site = SITE_W'(SITES - 1);
            else if (pick < 27)
                w.site = SITE_W'($urandom_range(SITES + 1, 255));
            else
                w.site = SITE_W'($urandom_range(0, SITES - 2));
            // pull the uniform onto the probability edge now and then
            p = (w.site == SITE_W'(SITES)) ? entry_q : exit_q;
            case ($urandom_range(0, 15))
                0: w.uniform = '0;
                1: w.uniform = '1;
                2: if (p != 0 && p <= 17'd65536) w.uniform = 16'(p - 1);
                3: if (p <= 17'd65535) w.uniform = 16'(p);
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic run_phase(input int fill_pct, input int n_words);
        repeat (24)
            send_word(mk(REQ_WRITE, $urandom_range(0, SITES - 1),
                         $urandom_range(0, 99) < fill_pct, $urandom));
        repeat (n_words)
            send_word(random_word());
        end_burst();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_boundary_moves();
        send_word(mk(REQ_READ, 0, 0, 0));
        send_word(mk(REQ_STEP, SITES, 0, 16'hFFFF));             // entry draw fails
        send_word(mk(REQ_STEP, SITES, 1, ENTRY_PROB_RST - 1));   // just under: entry
        send_word(mk(REQ_STEP, SITES, 0, 0));                    // site 0 taken
        send_word(mk(REQ_STEP, 0, 0, 0));                        // hop 0 -> 1
        send_word(mk(REQ_WRITE, SITES - 1, 1, 0));
        send_word(mk(REQ_WRITE, SITES - 2, 1, 16'hFFFF));
        send_word(mk(REQ_STEP, SITES - 2, 0, 0));                // blocked hop
        send_word(mk(REQ_STEP, SITES - 1, 0, EXIT_PROB_RST));    // exactly at prob: stays
        send_word(mk(REQ_STEP, SITES - 1, 0, EXIT_PROB_RST - 1));
        send_word(mk(REQ_STEP, SITES - 1, 1, 0));                // exit from empty site
        send_word(mk(REQ_STEP, SITES - 2, 1, 0));                // hop into last site
    endtask

    task automatic test_invalid_requests();
        send_word(mk(REQ_WRITE, 200, 1, 0));
        send_word(mk(REQ_READ, 200, 0, 0));
        send_word(mk(REQ_READ, SITES, 1, 16'hFFFF));
        send_word(mk(REQ_STEP, 255, 1, 0));
        send_word(mk(REQ_STEP, SITES + 1, 0, 0));
        send_word(mk(REQ_UNUSED, 8'hAA, 1, 16'h5555));
        end_burst();
    endtask

    task automatic test_sampling_rules();
        // sample on every step
        set_config(entry_q, exit_q, 16'd1, 32'd0, 1'b1);
        send_word(mk(REQ_STEP, SITES, 0, 0));
        send_word(mk(REQ_READ, SITES - 1, 0, 0));
        end_burst();
        // zero interval disables sampling
        set_config(entry_q, exit_q, 16'd0, 32'd0, 1'b0);
        send_word(mk(REQ_STEP, 10, 0, 0));
        send_word(mk(REQ_READ, SITES - 1, 0, 0));
        end_burst();
    endtask

    task automatic test_config_extremes();
        set_config(17'd65536, 17'd0, 16'd1, step_total + 20, 1'b0);
        run_phase(30, 106);
        set_config(17'd0, 17'd65536, 16'd3, 32'd0, 1'b1);
        run_phase(80, 106);
        set_config(17'h1FFFF, 17'h1FFFF, 16'd65535, 32'hFFFF_FFFF, 1'b0);
        run_phase(50, 106);
        set_config(17'd1, 17'd65535, 16'd2, 32'd0, 1'b0);
        run_phase(95, 106);
    endtask

    task automatic test_random_traffic();
        bit [PROB_W-1:0]     e;
        bit [PROB_W-1:0]     x;
        bit [INTERVAL_W-1:0] iv;
        bit [STEP_W-1:0]     wu;
        repeat (7)
        begin
            e  = ($urandom_range(0, 7) == 0) ? 17'h1FFFF :
                                               PROB_W'($urandom_range(0, 65536));
            x  = ($urandom_range(0, 7) == 0) ? 17'h1FFFF :
                                               PROB_W'($urandom_range(0, 65536));
            case ($urandom_range(0, 7))
                0:       iv = INTERVAL_W'($urandom_range(1, 65535));
                1:       iv = '0;
                default: iv = INTERVAL_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 5))
                0:       wu = '0;
                1:       wu = '1;
                default: wu = step_total + $urandom_range(0, 60);
            endcase
            set_config(e, x, iv, wu, $urandom_range(0, 3) == 0);
            run_phase($urandom_range(5, 95), 106);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: switches between no stall, random stall and stall bursts
    // ------------------------------------------------------------------
    int stall_mode;
    int mode_left;
    int hold_left;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(STALL_OFF, STALL_BURSTS);
            mode_left  <= $urandom_range(20, 120);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            STALL_RANDOM:
                out_stall <= ($urandom_range(0, 2) == 0);
            STALL_BURSTS:
            begin
                if (hold_left != 0)
                begin
                    out_stall <= 1'b1;
                    hold_left <= hold_left - 1;
                end
                else
                begin
                    out_stall <= 1'b0;
                    hold_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
                end
            end
            default:
                out_stall <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tlu_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: %h", out_word);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (out_word.action !== want.action)
                begin
                    $error("action: expected %0d, got %0d", want.action, out_word.action);
                    error_count++;
                end
                if (out_word.sampled !== want.sampled)
                begin
                    $error("sampled: expected %0d, got %0d", want.sampled, out_word.sampled);
                    error_count++;
                end
                if (out_word.occupied !== want.occupied)
                begin
                    $error("occupied: expected %0d, got %0d",
                           want.occupied, out_word.occupied);
                    error_count++;
                end
                if (out_word.density_count !== want.density_count)
                begin
                    $error("density_count: expected %0d, got %0d",
                           want.density_count, out_word.density_count);
                    error_count++;
                end
            end
        end
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("tasep_lattice_update_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        test_boundary_moves();
        test_invalid_requests();
        test_sampling_rules();
        test_config_extremes();
        test_random_traffic();

        wait_idle();
        // a stray late word would land within the pipeline depth
        repeat (4)
            @(posedge clk);

        $display("%0d words in, %0d results checked, %0d register settings",
                 words_sent, results_checked, settings_used);
        $display("moves: %0d entry, %0d exit, %0d hop, %0d none; %0d density samples",
                 move_tally[ACT_ENTRY], move_tally[ACT_EXIT], move_tally[ACT_HOP],
                 move_tally[ACT_NONE], samples_taken);
        if (error_count == 0)
            $display("tasep_lattice_update_test: clean");
        else
            $display("tasep_lattice_update_test: errors");
        $finish;
    end

endmodule
